// ----- src/dq_pkg.sv -----
// Package for the double-ended queue: command codes, payload structs and
// defaults for the top-level parameters. Used by every module of the block but dq_ram.
package dq_pkg;

  localparam int unsigned DqDepth    = 16;
  localparam int unsigned DqWordBits = 32;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned FillW      = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REWIND     = 3'd4,
    CMD_READ_NEXT  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] value;
  } dq_item_t;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             data_valid;
    logic             is_empty;
    logic [FillW-1:0] fill_count;
    logic             push_refused;
  } dq_result_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } dq_ctrl_t;

endpackage

// ----- src/dq_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dq_ctrl.sv -----
// Controller of the double-ended queue: sequences accept, access and result.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output dq_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  always_comb begin
    case (state_q)
      ST_IDLE:   state_d = start ? ST_ACCESS : ST_IDLE;
      ST_ACCESS: state_d = ST_RESULT;
      ST_RESULT: state_d = start ? ST_ACCESS : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d == ST_ACCESS);
      done_q  <= (state_d == ST_RESULT);
    end
  end

  assign busy        = busy_q;
  assign ctrl_o.load = start && !busy_q;
  assign ctrl_o.exec = busy_q;
  assign ctrl_o.emit = done_q;

endmodule

// ----- src/dq_datapath.sv -----
// Datapath of the double-ended queue: ring pointers, cursor, count and the
// slot RAM. Depends on dq_pkg and dq_ram.
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned Depth    = DqDepth,
  parameter int unsigned WordBits = DqWordBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dq_ctrl_t   ctrl_i,
  input  dq_item_t   item_i,
  output dq_result_t result_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  logic [CmdW-1:0]     cmd_q;
  logic [WordBits-1:0] value_q;
  logic [IdxW-1:0]     head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                act_q, act_d;
  logic                valid_q, valid_d, refused_q, refused_d;
  logic                we, re;
  logic [IdxW-1:0]     addr, back;
  logic [WordBits-1:0] rdata;
  logic                full, empty, last;

  assign full  = (count_q == FullCnt);
  assign empty = (count_q == '0);
  assign last  = (count_q == CntW'(1));
  assign back  = ring_prev(tail_q);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cur_d     = cur_q;
    count_d   = count_q;
    act_d     = act_q;
    valid_d   = 1'b0;
    refused_d = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    addr      = head_q;
    case (cmd_q)
      CMD_PUSH_FRONT: begin
        if (full) begin
          refused_d = 1'b1;
        end else begin
          head_d  = ring_prev(head_q);
          addr    = ring_prev(head_q);
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          refused_d = 1'b1;
        end else begin
          addr    = tail_q;
          tail_d  = ring_next(tail_q);
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (!empty) begin
          addr    = head_q;
          re      = 1'b1;
          valid_d = 1'b1;
          if (act_q && cur_q == head_q) begin
            act_d = 1'b0;
          end
          head_d  = ring_next(head_q);
          count_d = count_q - 1'b1;
          if (last) begin
            cur_d = '0;
            act_d = 1'b0;
          end
        end
      end
      CMD_POP_BACK: begin
        if (!empty) begin
          addr    = back;
          re      = 1'b1;
          valid_d = 1'b1;
          if (act_q && cur_q == back) begin
            act_d = 1'b0;
          end
          tail_d  = back;
          count_d = count_q - 1'b1;
          if (last) begin
            cur_d = '0;
            act_d = 1'b0;
          end
        end
      end
      CMD_REWIND: begin
        cur_d = head_q;
        act_d = !empty;
      end
      CMD_READ_NEXT: begin
        if (act_q && !empty) begin
          addr    = cur_q;
          re      = 1'b1;
          valid_d = 1'b1;
          if (cur_q == back) begin
            act_d = 1'b0;
          end else begin
            cur_d = ring_next(cur_q);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= item_i.cmd;
      value_q <= WordBits'(item_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      cur_q     <= '0;
      count_q   <= '0;
      act_q     <= 1'b0;
      valid_q   <= 1'b0;
      refused_q <= 1'b0;
    end else if (ctrl_i.exec) begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      cur_q     <= cur_d;
      count_q   <= count_d;
      act_q     <= act_d;
      valid_q   <= valid_d;
      refused_q <= refused_d;
    end
  end

  dq_ram #(
    .Width (WordBits),
    .Depth (Depth)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.exec && we),
    .re_i    (ctrl_i.exec && re),
    .addr_i  (addr),
    .wdata_i (value_q),
    .rdata_o (rdata)
  );

  // The receiver must sample the result fields only while the result strobe is high; the block does not enforce it.
  always_comb begin
    result_o.data         = (ctrl_i.emit && valid_q) ? DataW'(rdata) : '0;
    result_o.data_valid   = ctrl_i.emit && valid_q;
    result_o.is_empty     = empty;
    result_o.fill_count   = FillW'(count_q);
    result_o.push_refused = ctrl_i.emit && refused_q;
  end

endmodule

// ----- src/double_ended_queue.sv -----
// Double-ended queue of data words on a ring of Depth slots in one RAM.
// done_o is high in the result state, which follows the access state after the start
// transfer; a new command is taken in the idle or the result state, not while busy;
// busy is high only in the access cycle, and the receiver cannot stall.
// Reset (rst_ni, asynchronous, active low) gives an empty queue with no cursor;
// slot contents are left undefined until written.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned Depth    = DqDepth,
  parameter int unsigned WordBits = DqWordBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dq_item_t   item_i,
  output logic       done_o,
  output dq_result_t result_o
);

  dq_ctrl_t ctrl;

  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  dq_datapath #(
    .Depth    (Depth),
    .WordBits (WordBits)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .item_i   (item_i),
    .result_o (result_o)
  );

  assign done_o = ctrl.emit;

endmodule
